// File: hdl/trip_fe_pkg.sv
// ----------------------------------------------------------------------------
// trip_fe_pkg
// Shared types, codes and reset values of the trip fuel economy history unit.
// ----------------------------------------------------------------------------
package trip_fe_pkg;

   localparam int DATA_W = 32;
   localparam int ECON_W = 16;
   localparam int CFG_IDX_W = 3;

   // opcodes
   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_CLEAR_HIST = 2'd1;
   localparam logic [1:0] OP_ACCEPT_BEST = 2'd2;
   localparam logic [1:0] OP_CLEAR_UPD  = 2'd3;

   // register indexes
   localparam logic [CFG_IDX_W-1:0] REG_ENGINE_SPEED_MIN  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_MIN_ON_TICKS      = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_MIN_TRIP_DISTANCE = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIP_DISTANCE = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_MAX_ECONOMY       = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ECONOMY   = 3'd5;

   // economy flag codes
   localparam logic [1:0] ECON_NONE       = 2'd0;
   localparam logic [1:0] ECON_NOT_BETTER = 2'd1;
   localparam logic [1:0] ECON_BETTER     = 2'd2;

   // reset values
   localparam logic [15:0] RST_ENGINE_SPEED_MIN  = 16'd170;
   localparam logic [15:0] RST_MIN_ON_TICKS      = 16'd300;
   localparam logic [31:0] RST_MIN_TRIP_DISTANCE = 32'd500;
   localparam logic [31:0] RST_MAX_TRIP_DISTANCE = 32'd999999;
   localparam logic [15:0] RST_MAX_ECONOMY       = 16'd300;
   localparam logic [15:0] RST_INITIAL_ECONOMY   = 16'd300;
   localparam logic [15:0] RST_TOTAL_AVG         = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        ignition_on;
      logic        speed_valid;
      logic        fuel_rate_valid;
      logic [15:0] engine_speed;
      logic        engine_speed_valid;
      logic [31:0] odometer_meters;
      logic [15:0] fuel_used;
      logic [2:0]  history_index;
   } item_type;

   typedef struct packed {
      logic [15:0] last_economy;
      logic [15:0] total_economy;
      logic [15:0] best_economy;
      logic [15:0] history_value;
      logic [1:0]  economy_flag;
      logic        best_flag;
      logic        update_flag;
      logic [15:0] current_economy;
   } result_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic sum_start;
      logic div_start;
      logic div_sel_last;
      logic close;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic close_needed;
      logic sum_done;
      logic div_done;
   } sts_type;

   function automatic logic beats_best(input logic [15:0] v, input logic [15:0] best,
                                       input logic [15:0] init);
      beats_best = (v < best) || ((best == init) && (v != init));
   endfunction

endpackage

// File: hdl/trip_fe_div.sv
// ----------------------------------------------------------------------------
// trip_fe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trip_fe_div import trip_fe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] num,
   input  logic [DATA_W-1:0] den,
   output logic              done,
   output logic [DATA_W-1:0] quot
);

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;

   assign shifted = {rem_ff, acc_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         acc_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            acc_in = {acc_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            acc_in = {acc_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = acc_ff;

endmodule

// File: hdl/trip_fe_datapath.sv
// ----------------------------------------------------------------------------
// trip_fe_datapath
// Trip accumulators, slot ring, history shift line, averages and result.
// ----------------------------------------------------------------------------
module trip_fe_datapath import trip_fe_pkg::*; #(
   parameter int HISTORY_DEPTH = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   input  item_type             req_item,
   input  cmd_type              cmd,
   output sts_type              sts,
   output result_type           rsp_data
);

   localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HW = 5;

   // configuration
   logic [15:0] speed_min_ff, min_ticks_ff, max_econ_ff, init_econ_ff;
   logic [31:0] min_dist_ff, max_dist_ff;

   item_type    item_ff;

   logic [15:0] hist_ff [HISTORY_DEPTH];
   logic [31:0] fuel_mem [HISTORY_DEPTH];
   logic [31:0] dist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] slot_vld_ff;

   logic [SW-1:0] slot_idx_ff, slot_idx_in;
   logic [15:0]   total_ff, total_in;
   logic [15:0]   best_ff, best_in;
   logic [1:0]    estate_ff, estate_in;
   logic          best_seen_ff, best_seen_in;
   logic          changed_ff, changed_in;
   logic [15:0]   shown_ff, shown_in;
   logic [31:0]   trip_dist_ff, trip_dist_in;
   logic [31:0]   trip_fuel_ff, trip_fuel_in;
   logic [15:0]   on_ticks_ff, on_ticks_in;
   logic          trip_valid_ff, trip_valid_in;
   logic          ign_was_ff, ign_was_in;
   logic [31:0]   odo_last_ff, odo_last_in;
   logic [31:0]   cur_dist_ff, cur_dist_in;
   logic [31:0]   cur_fuel_ff, cur_fuel_in;
   logic          hist_clear;
   logic          slot_write;

   // ring sum
   logic [SW-1:0] sum_addr_ff;
   logic          sum_run_ff;
   logic          rd_vld_ff, rd_last_ff;
   logic [31:0]   rd_fuel_ff, rd_dist_ff;
   logic [31:0]   sf_ff, sd_ff;

   // division
   logic          div_sel_ff;
   logic [15:0]   last_q_ff;
   logic [31:0]   div_num, div_den, div_quot, den_now;
   logic          div_done;
   logic [15:0]   sat_q;

   result_type    rsp_ff;

   logic          qualified;
   logic [31:0]   odo_diff;
   logic [15:0]   advance;
   logic [HW-1:0] hi_ext;
   logic [SW-1:0] hi_sel;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_min_ff <= RST_ENGINE_SPEED_MIN;
         min_ticks_ff <= RST_MIN_ON_TICKS;
         min_dist_ff  <= RST_MIN_TRIP_DISTANCE;
         max_dist_ff  <= RST_MAX_TRIP_DISTANCE;
         max_econ_ff  <= RST_MAX_ECONOMY;
         init_econ_ff <= RST_INITIAL_ECONOMY;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENGINE_SPEED_MIN:  speed_min_ff <= csr_wdata[15:0];
            REG_MIN_ON_TICKS:      min_ticks_ff <= csr_wdata[15:0];
            REG_MIN_TRIP_DISTANCE: min_dist_ff  <= csr_wdata;
            REG_MAX_TRIP_DISTANCE: max_dist_ff  <= csr_wdata;
            REG_MAX_ECONOMY:       max_econ_ff  <= csr_wdata[15:0];
            REG_INITIAL_ECONOMY:   init_econ_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_item;
      end
   end

   assign qualified = item_ff.speed_valid && item_ff.fuel_rate_valid &&
                      (item_ff.engine_speed > speed_min_ff) && item_ff.engine_speed_valid;
   assign odo_diff  = item_ff.odometer_meters - odo_last_ff;

   assign sts.close_needed = (item_ff.opcode == OP_TICK) && !item_ff.ignition_on &&
                             trip_valid_ff;
   assign sts.sum_done = rd_vld_ff && rd_last_ff;
   assign sts.div_done = div_done;

   assign den_now = div_sel_ff ? cur_dist_ff : sd_ff;
   assign sat_q   = (den_now == '0) ? max_econ_ff :
                    ((div_quot > {16'd0, max_econ_ff}) ? max_econ_ff : div_quot[15:0]);

   always_comb begin
      slot_idx_in   = slot_idx_ff;
      total_in      = total_ff;
      best_in       = best_ff;
      estate_in     = estate_ff;
      best_seen_in  = best_seen_ff;
      changed_in    = changed_ff;
      shown_in      = shown_ff;
      trip_dist_in  = trip_dist_ff;
      trip_fuel_in  = trip_fuel_ff;
      on_ticks_in   = on_ticks_ff;
      trip_valid_in = trip_valid_ff;
      ign_was_in    = ign_was_ff;
      odo_last_in   = odo_last_ff;
      cur_dist_in   = cur_dist_ff;
      cur_fuel_in   = cur_fuel_ff;
      hist_clear    = 1'b0;
      slot_write    = 1'b0;
      advance       = '0;
      if (cmd.exec) begin
         case (item_ff.opcode)
            OP_TICK: begin
               if (item_ff.ignition_on) begin
                  if (!ign_was_ff) begin
                     ign_was_in = 1'b1;
                     estate_in  = ECON_NONE;
                     changed_in = 1'b1;
                     shown_in   = '0;
                  end
                  if (qualified) begin
                     if (on_ticks_ff < min_ticks_ff) begin
                        on_ticks_in   = on_ticks_ff + 16'd1;
                        trip_valid_in = 1'b0;
                     end else if (trip_dist_ff > min_dist_ff) begin
                        trip_valid_in = 1'b1;
                     end
                     if (trip_dist_ff < max_dist_ff) begin
                        // a qualified tick with no odometer baseline yet takes one and adds no distance
                        if (odo_last_ff == '0) begin
                           odo_last_in = item_ff.odometer_meters;
                        end else if (item_ff.odometer_meters > odo_last_ff) begin
                           advance     = odo_diff[15:0];
                           odo_last_in = item_ff.odometer_meters;
                        end
                        trip_dist_in = trip_dist_ff + {16'd0, advance};
                        trip_fuel_in = trip_fuel_ff + {16'd0, item_ff.fuel_used};
                     end
                  end
               end else begin
                  if (ign_was_ff) begin
                     ign_was_in = 1'b0;
                     changed_in = 1'b1;
                  end
                  on_ticks_in   = '0;
                  slot_write    = 1'b1;
                  trip_valid_in = 1'b0;
                  cur_dist_in   = trip_dist_ff;
                  cur_fuel_in   = trip_fuel_ff;
                  trip_dist_in  = '0;
                  trip_fuel_in  = '0;
               end
            end
            OP_CLEAR_HIST: begin
               hist_clear    = 1'b1;
               slot_idx_in   = '0;
               trip_valid_in = 1'b0;
               estate_in     = ECON_NONE;
               best_seen_in  = 1'b0;
               total_in      = RST_TOTAL_AVG;
               best_in       = init_econ_ff;
               shown_in      = '0;
               changed_in    = 1'b1;
            end
            OP_ACCEPT_BEST: begin
               changed_in = 1'b1;
               if (beats_best(hist_ff[0], best_ff, init_econ_ff)) begin
                  best_in      = hist_ff[0];
                  best_seen_in = 1'b1;
                  estate_in    = ECON_NONE;
               end
            end
            OP_CLEAR_UPD: begin
               changed_in = 1'b0;
            end
            default: ;
         endcase
      end
      if (div_done && !div_sel_ff) begin
         total_in = sat_q;
      end
      if (cmd.close) begin
         estate_in  = beats_best(last_q_ff, best_ff, init_econ_ff) ? ECON_BETTER :
                      ECON_NOT_BETTER;
         shown_in   = last_q_ff;
         changed_in = 1'b1;
         if (slot_idx_ff == SW'(HISTORY_DEPTH - 1)) begin
            slot_idx_in = '0;
         end else begin
            slot_idx_in = slot_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_idx_ff   <= '0;
         total_ff      <= RST_TOTAL_AVG;
         best_ff       <= RST_INITIAL_ECONOMY;
         estate_ff     <= ECON_NONE;
         best_seen_ff  <= 1'b0;
         changed_ff    <= 1'b0;
         shown_ff      <= '0;
         trip_dist_ff  <= '0;
         trip_fuel_ff  <= '0;
         on_ticks_ff   <= '0;
         trip_valid_ff <= 1'b0;
         ign_was_ff    <= 1'b0;
         odo_last_ff   <= '0;
      end else begin
         slot_idx_ff   <= slot_idx_in;
         total_ff      <= total_in;
         best_ff       <= best_in;
         estate_ff     <= estate_in;
         best_seen_ff  <= best_seen_in;
         changed_ff    <= changed_in;
         shown_ff      <= shown_in;
         trip_dist_ff  <= trip_dist_in;
         trip_fuel_ff  <= trip_fuel_in;
         on_ticks_ff   <= on_ticks_in;
         trip_valid_ff <= trip_valid_in;
         ign_was_ff    <= ign_was_in;
         odo_last_ff   <= odo_last_in;
      end
      cur_dist_ff <= cur_dist_in;
      cur_fuel_ff <= cur_fuel_in;
   end

   // history shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= RST_INITIAL_ECONOMY;
         end
      end else if (hist_clear) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= init_econ_ff;
         end
      end else if (cmd.close) begin
         for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
            hist_ff[i] <= hist_ff[i-1];
         end
         hist_ff[0] <= last_q_ff;
      end
   end

   // slot ring: per-entry valid bits, an invalid entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
      end else if (hist_clear) begin
         slot_vld_ff <= '0;
      end else if (slot_write) begin
         slot_vld_ff[slot_idx_ff] <= 1'b1;
      end
      if (slot_write) begin
         fuel_mem[slot_idx_ff] <= trip_fuel_ff;
         dist_mem[slot_idx_ff] <= trip_dist_ff;
      end
      rd_fuel_ff <= slot_vld_ff[sum_addr_ff] ? fuel_mem[sum_addr_ff] : '0;
      rd_dist_ff <= slot_vld_ff[sum_addr_ff] ? dist_mem[sum_addr_ff] : '0;
   end

   // ring sum, one slot per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_run_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rd_last_ff <= 1'b0;
         sum_addr_ff <= '0;
      end else if (cmd.sum_start) begin
         sum_run_ff  <= 1'b1;
         rd_vld_ff   <= 1'b0;
         rd_last_ff  <= 1'b0;
         sum_addr_ff <= '0;
      end else begin
         rd_vld_ff  <= sum_run_ff;
         rd_last_ff <= sum_run_ff && (sum_addr_ff == SW'(HISTORY_DEPTH - 1));
         if (sum_run_ff) begin
            if (sum_addr_ff == SW'(HISTORY_DEPTH - 1)) begin
               sum_run_ff  <= 1'b0;
               sum_addr_ff <= '0;
            end else begin
               sum_addr_ff <= sum_addr_ff + 1'b1;
            end
         end
      end
      if (cmd.sum_start) begin
         sf_ff <= '0;
         sd_ff <= '0;
      end else if (rd_vld_ff) begin
         sf_ff <= sf_ff + rd_fuel_ff;
         sd_ff <= sd_ff + rd_dist_ff;
      end
   end

   assign div_num = cmd.div_sel_last ? cur_fuel_ff : sf_ff;
   assign div_den = cmd.div_sel_last ? cur_dist_ff : sd_ff;

   trip_fe_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_sel_ff <= cmd.div_sel_last;
      end
      if (div_done && div_sel_ff) begin
         last_q_ff <= sat_q;
      end
   end

   // out-of-range index reports the oldest entry
   assign hi_ext = HW'(item_ff.history_index);
   assign hi_sel = (hi_ext >= HW'(HISTORY_DEPTH)) ? SW'(HISTORY_DEPTH - 1) : hi_ext[SW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.last_economy    <= hist_ff[0];
         rsp_ff.total_economy   <= total_ff;
         rsp_ff.best_economy    <= best_ff;
         rsp_ff.history_value   <= hist_ff[hi_sel];
         rsp_ff.economy_flag    <= estate_ff;
         rsp_ff.best_flag       <= best_seen_ff;
         rsp_ff.update_flag     <= changed_ff;
         rsp_ff.current_economy <= shown_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hdl/trip_fe_ctrl.sv
// ----------------------------------------------------------------------------
// trip_fe_ctrl
// Sequencer: execute, ring sum, two divisions, close and result handoff.
// ----------------------------------------------------------------------------
module trip_fe_ctrl import trip_fe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EXEC   = 4'd1;
   localparam logic [3:0] S_SUM    = 4'd2;
   localparam logic [3:0] S_DIVT   = 4'd3;
   localparam logic [3:0] S_WAITT  = 4'd4;
   localparam logic [3:0] S_DIVL   = 4'd5;
   localparam logic [3:0] S_WAITL  = 4'd6;
   localparam logic [3:0] S_CLOSE  = 4'd7;
   localparam logic [3:0] S_RESULT = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.close_needed) begin
               cmd.sum_start = 1'b1;
               state_in      = S_SUM;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_SUM: begin
            if (sts.sum_done) begin
               state_in = S_DIVT;
            end
         end
         S_DIVT: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAITT;
         end
         S_WAITT: begin
            if (sts.div_done) begin
               state_in = S_DIVL;
            end
         end
         S_DIVL: begin
            cmd.div_start    = 1'b1;
            cmd.div_sel_last = 1'b1;
            state_in         = S_WAITL;
         end
         S_WAITL: begin
            if (sts.div_done) begin
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hdl/trip_fuel_economy_history_unit.sv
// ----------------------------------------------------------------------------
// trip_fuel_economy_history_unit
// Trip distance/fuel accumulation with a ring of trip slots and economy history.
// ----------------------------------------------------------------------------
// commands and ticks that close no trip run EXEC, then RESULT loads the result
// closing a trip runs the ring sum, one slot a cycle, then two divisions on one
//   shared bit-serial divider and the close; RESULT waits while a result is untaken
// one beat in work at a time; the result register frees the input while a beat waits
// synchronous active-high reset restores state, history and slot valid bits at once
module trip_fuel_economy_history_unit import trip_fe_pkg::*; #(
   parameter int HISTORY_DEPTH = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // ignition_on, speed_valid, fuel_rate_valid, engine_speed[15:0],
   // engine_speed_valid, odometer_meters[31:0], fuel_used[15:0], history_index[2:0]
   input  logic [71:0]          req_tdata,
   // opcode[1:0]
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // last_economy, total_economy, best_economy, history_value, economy_flag[1:0],
   // best_flag, update_flag, current_economy
   output logic [87:0]          rsp_tdata,
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   item_type   req_item;
   result_type rsp_data;
   cmd_type    cmd;
   sts_type    sts;

   assign req_item.opcode             = req_tuser;
   assign req_item.ignition_on        = req_tdata[0];
   assign req_item.speed_valid        = req_tdata[1];
   assign req_item.fuel_rate_valid    = req_tdata[2];
   assign req_item.engine_speed       = req_tdata[18:3];
   assign req_item.engine_speed_valid = req_tdata[19];
   assign req_item.odometer_meters    = req_tdata[51:20];
   assign req_item.fuel_used          = req_tdata[67:52];
   assign req_item.history_index      = req_tdata[70:68];

   assign rsp_tdata = {4'd0, rsp_data.current_economy, rsp_data.update_flag,
                       rsp_data.best_flag, rsp_data.economy_flag, rsp_data.history_value,
                       rsp_data.best_economy, rsp_data.total_economy,
                       rsp_data.last_economy};

   trip_fe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   trip_fe_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
